// ===== hdl/blca_pkg.sv =====
// ----------------------------------------------------------------------------
// blca_pkg - shared types and constants for the binary lifting lca block
// Holds field widths, default sizes, the item opcodes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package blca_pkg;

    // width of every node, depth and count field
    localparam int EW = 10;

    // default table sizes
    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 10;

    // node_count after reset
    localparam logic [EW-1:0] NODE_COUNT_RST = 10'd1023;

    // stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    // item kinds carried in tuser
    typedef enum logic [IN_TUSER_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } t_opcode;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_DU,
        S_Q_DV,
        S_Q_SW,
        S_Q_LIFT,
        S_Q_LW,
        S_Q_CMP,
        S_Q_JU,
        S_Q_JV,
        S_Q_JC,
        S_Q_PAR,
        S_Q_PW,
        S_Q_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/binary_lifting_lca.sv =====
// Load: no result. Build: for each level 1 to LEVELS-1 and each node 1 to
// min(node_count, NODES-1), two jump reads in turn on the single read port, then a write.
// Query: both depth reads, a lift per set bit of the depth difference, a compare, then a
// jump pair per level from the top down and a parent read; each table read is registered.
// One item at a time; a finished result waits in the output register.
// Reset (synchronous, active low) idles the sequencer, empties the output and sets
// node_count to 1023; the jump and depth memories are not cleared.
// ----------------------------------------------------------------------------
// binary_lifting_lca - lowest common ancestor by binary lifting
// Parent/depth loads, jump table build and queries over two synchronous
// memories (jump table and depth table) driven by one sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_lifting_lca #(
    parameter int NODES  = blca_pkg::NODES_DEF,
    parameter int LEVELS = blca_pkg::LEVELS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration: node_count
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [blca_pkg::EW-1:0]        i_cfg_wr_data,
    // input stream
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    // first_node[9:0], second_node[19:10], parent_node[29:20], node_depth[39:30]
    input  wire logic [blca_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // opcode[1:0]
    input  wire logic [blca_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    // result stream
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // common_ancestor[9:0], zero fill above
    output      logic [blca_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import blca_pkg::*;

    localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JD  = LEVELS * NODES;
    localparam int JAW = (JD > 1) ? $clog2(JD) : 1;
    localparam logic [JAW-1:0] NODES_A = JAW'(NODES);

    // node number at or above NODES reads as none
    function automatic logic [EW-1:0] f_node(input logic [EW-1:0] n);
        return (32'(n) < NODES) ? n : '0;
    endfunction

    // flat jump memory address of (level, node)
    function automatic logic [JAW-1:0] f_jaddr(input logic [LW-1:0] lvl,
                                               input logic [EW-1:0] n);
        return JAW'(lvl) * NODES_A + JAW'(NW'(n));
    endfunction

    // memories
    logic [EW-1:0] r_jump_mem  [JD];
    logic [EW-1:0] r_depth_mem [NODES];
    logic [EW-1:0] r_jq, r_dq;
    logic          r_jz, r_dz;

    // control and working registers
    t_state        r_state, n_state;
    logic [EW-1:0] r_node_count;
    logic [EW-1:0] r_u, n_u, r_v, n_v;
    logic [EW-1:0] r_du, n_du;
    logic [EW-1:0] r_diff, n_diff;
    logic [EW-1:0] r_pu, n_pu;
    logic [EW-1:0] r_res, n_res;
    logic [EW-1:0] r_last, n_last;
    logic [LW-1:0] r_lvl, n_lvl;
    logic [EW-1:0] r_out, n_out;
    logic          r_ovalid, n_ovalid;

    // memory access requests
    logic          jr_en;
    logic [LW-1:0] jr_lvl;
    logic [EW-1:0] jr_node;
    logic          jw_en;
    logic [LW-1:0] jw_lvl;
    logic [EW-1:0] jw_node, jw_data;
    logic          dr_en;
    logic [EW-1:0] dr_node;
    logic          dw_en;

    // input fields
    t_opcode       in_op;
    logic [EW-1:0] in_first, in_second, in_parent, in_depth;
    logic [EW-1:0] jval, dval;
    logic [EW-1:0] last_cap, diff_w;
    logic          in_acc;

    assign in_op     = t_opcode'(s_axis_tuser);
    assign in_first  = s_axis_tdata[EW-1:0];
    assign in_second = s_axis_tdata[2*EW-1:EW];
    assign in_parent = s_axis_tdata[3*EW-1:2*EW];
    assign in_depth  = s_axis_tdata[4*EW-1:3*EW];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

    // read data, none when the address node was none
    assign jval = r_jz ? '0 : r_jq;
    assign dval = r_dz ? '0 : r_dq;

    // build range clipped to the table
    assign last_cap = (32'(r_node_count) > NODES - 1) ? EW'(NODES - 1) : r_node_count;

    // jump table memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (jw_en) begin
            r_jump_mem[f_jaddr(jw_lvl, jw_node)] <= jw_data;
        end
        if (jr_en) begin
            r_jq <= r_jump_mem[f_jaddr(jr_lvl, f_node(jr_node))];
            r_jz <= (f_node(jr_node) == '0);
        end
    end

    // depth table memory
    always_ff @(posedge i_clk) begin
        if (dw_en) begin
            r_depth_mem[NW'(in_first)] <= in_depth;
        end
        if (dr_en) begin
            r_dq <= r_depth_mem[NW'(f_node(dr_node))];
            r_dz <= (f_node(dr_node) == '0);
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_node_count <= i_cfg_wr_data;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_u    <= n_u;
        r_v    <= n_v;
        r_du   <= n_du;
        r_diff <= n_diff;
        r_pu   <= n_pu;
        r_res  <= n_res;
        r_last <= n_last;
        r_lvl  <= n_lvl;
        r_out  <= n_out;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_u      = r_u;
        n_v      = r_v;
        n_du     = r_du;
        n_diff   = r_diff;
        n_pu     = r_pu;
        n_res    = r_res;
        n_last   = r_last;
        n_lvl    = r_lvl;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        jr_en    = 1'b0;
        jr_lvl   = r_lvl;
        jr_node  = r_u;
        jw_en    = 1'b0;
        jw_lvl   = r_lvl;
        jw_node  = r_u;
        jw_data  = jval;
        dr_en    = 1'b0;
        dr_node  = r_u;
        dw_en    = 1'b0;
        diff_w   = '0;

        // output register drains
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_LOAD: begin
                            if (f_node(in_first) != '0) begin
                                jw_en   = 1'b1;
                                jw_lvl  = '0;
                                jw_node = in_first;
                                jw_data = f_node(in_parent);
                                dw_en   = 1'b1;
                            end
                        end
                        OP_BUILD: begin
                            if (LEVELS > 1 && last_cap != '0) begin
                                n_last  = last_cap;
                                n_lvl   = LW'(1);
                                n_u     = EW'(1);
                                n_state = S_B_RD1;
                            end
                        end
                        OP_QUERY: begin
                            n_u     = f_node(in_first);
                            n_v     = f_node(in_second);
                            n_state = S_Q_DU;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // build: jump[k][u] = jump[k-1][jump[k-1][u]]
            S_B_RD1: begin
                jr_en   = 1'b1;
                jr_lvl  = r_lvl - 1'b1;
                jr_node = r_u;
                n_state = S_B_RD2;
            end
            S_B_RD2: begin
                jr_en   = 1'b1;
                jr_lvl  = r_lvl - 1'b1;
                jr_node = jval;
                n_state = S_B_WR;
            end
            S_B_WR: begin
                jw_en   = 1'b1;
                jw_lvl  = r_lvl;
                jw_node = r_u;
                jw_data = jval;
                if (r_u == r_last) begin
                    if (32'(r_lvl) == LEVELS - 1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_lvl   = r_lvl + 1'b1;
                        n_u     = EW'(1);
                        n_state = S_B_RD1;
                    end
                end else begin
                    n_u     = r_u + 1'b1;
                    n_state = S_B_RD1;
                end
            end

            // query: fetch both depths
            S_Q_DU: begin
                dr_en   = 1'b1;
                dr_node = r_u;
                n_state = S_Q_DV;
            end
            S_Q_DV: begin
                n_du    = dval;
                dr_en   = 1'b1;
                dr_node = r_v;
                n_state = S_Q_SW;
            end

            // deeper node into u, depth difference
            S_Q_SW: begin
                if (r_du < dval) begin
                    n_u    = r_v;
                    n_v    = r_u;
                    diff_w = dval - r_du;
                end else begin
                    diff_w = r_du - dval;
                end
                n_diff = diff_w;
                if ((diff_w >> LEVELS) != '0) begin
                    n_u    = '0;
                    n_diff = '0;
                end
                n_lvl   = '0;
                n_state = S_Q_LIFT;
            end

            // lift u one set bit of the difference at a time
            S_Q_LIFT: begin
                if (r_diff == '0) begin
                    n_state = S_Q_CMP;
                end else if (r_diff[0]) begin
                    jr_en   = 1'b1;
                    jr_lvl  = r_lvl;
                    jr_node = r_u;
                    n_state = S_Q_LW;
                end else begin
                    n_diff = r_diff >> 1;
                    n_lvl  = r_lvl + 1'b1;
                end
            end
            S_Q_LW: begin
                n_u     = jval;
                n_diff  = r_diff >> 1;
                n_lvl   = r_lvl + 1'b1;
                n_state = S_Q_LIFT;
            end

            S_Q_CMP: begin
                if (r_u == r_v) begin
                    n_res   = r_u;
                    n_state = S_Q_DONE;
                end else begin
                    n_lvl   = LW'(LEVELS - 1);
                    n_state = S_Q_JU;
                end
            end

            // jump both nodes from the top level down
            S_Q_JU: begin
                jr_en   = 1'b1;
                jr_lvl  = r_lvl;
                jr_node = r_u;
                n_state = S_Q_JV;
            end
            S_Q_JV: begin
                n_pu    = jval;
                jr_en   = 1'b1;
                jr_lvl  = r_lvl;
                jr_node = r_v;
                n_state = S_Q_JC;
            end
            S_Q_JC: begin
                if (r_pu != '0 && jval != '0 && r_pu != jval) begin
                    n_u = r_pu;
                    n_v = jval;
                end
                if (r_lvl == '0) begin
                    n_state = S_Q_PAR;
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = S_Q_JU;
                end
            end

            // answer is the direct parent
            S_Q_PAR: begin
                jr_en   = 1'b1;
                jr_lvl  = '0;
                jr_node = r_u;
                n_state = S_Q_PW;
            end
            S_Q_PW: begin
                n_res   = jval;
                n_state = S_Q_DONE;
            end

            // hand the result to the output register
            S_Q_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
